// ===== sv/rcg_pkg.sv =====
package rcg_pkg;

  localparam int PIX_W       = 8;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int COORD_OUT_W = 10;
  localparam int SQ_W        = 17;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic grad;
    logic copy_up;
    logic copy_self;
  } rcg_flags_t;

endpackage

// ===== sv/rcg_ram.sv =====
module rcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/rcg_fifo.sv =====
module rcg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, rptr_r;
  logic [NW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == NW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + NW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

// ===== sv/rcg_front.sv =====
module rcg_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [rcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcg_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rcg_pkg::pix_t                  in_gray_pixel,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [$clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH)
                + 4 * rcg_pkg::PIX_W + 3 - 1:0] q_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int DW_A = $clog2(MAX_WIDTH + 1);
  localparam int DW_B = $clog2(MAX_HEIGHT + 1);
  localparam int DW_C = (DW_A > DW_B) ? DW_A : DW_B;
  localparam int DW   = (DW_C > rcg_pkg::CFG_W) ? DW_C : rcg_pkg::CFG_W;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_READ = 1'b1;

  logic                     fst_r;
  logic [rcg_pkg::CFG_W-1:0] width_r, height_r;
  logic [DW-1:0]            w, h, wx, hx;
  logic [CW-1:0]            col_r, jc_r;
  logic [RW-1:0]            row_r, jr_r;
  logic [DW-1:0]            col_x, row_x, c_x, r_x, cn_x, rn_x;
  rcg_pkg::pix_t            cur_r, ul_r, left_r, upper;
  rcg_pkg::rcg_flags_t      flags_r, flags;
  logic                     accept;

  always_comb begin
    wx = DW'(width_r);
    hx = DW'(height_r);
    if (wx == '0) begin
      w = DW'(1);
    end else if (wx > DW'(MAX_WIDTH)) begin
      w = DW'(MAX_WIDTH);
    end else begin
      w = wx;
    end
    if (hx == '0) begin
      h = DW'(1);
    end else if (hx > DW'(MAX_HEIGHT)) begin
      h = DW'(MAX_HEIGHT);
    end else begin
      h = hx;
    end
  end

  always_comb begin
    col_x = DW'(col_r);
    row_x = DW'(row_r);
    if (col_x >= w) begin
      c_x = '0;
      r_x = row_x + DW'(1);
    end else begin
      c_x = col_x;
      r_x = row_x;
    end
    if (r_x >= h) begin
      r_x = '0;
    end
    cn_x = c_x + DW'(1);
    rn_x = r_x;
    if (cn_x >= w) begin
      cn_x = '0;
      rn_x = r_x + DW'(1);
      if (rn_x >= h) begin
        rn_x = '0;
      end
    end
    flags.grad      = (r_x != '0) && (c_x != '0);
    flags.copy_up   = (r_x != '0) && (c_x == w - DW'(1));
    flags.copy_self = (r_x == h - DW'(1));
  end

  assign in_ready = (fst_r == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = (fst_r == F_READ);
  assign q_data   = {flags_r, jr_r, jc_r, cur_r, upper, ul_r, left_r};

  rcg_ram #(
    .WIDTH (rcg_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (fst_r == F_READ),
    .waddr (jc_r),
    .wdata (cur_r),
    .raddr (CW'(c_x)),
    .rdata (upper)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      jr_r    <= RW'(r_x);
      jc_r    <= CW'(c_x);
      cur_r   <= in_gray_pixel;
      flags_r <= flags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r    <= F_IDLE;
      width_r  <= rcg_pkg::RESET_WIDTH;
      height_r <= rcg_pkg::RESET_HEIGHT;
      col_r    <= '0;
      row_r    <= '0;
      ul_r     <= '0;
      left_r   <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          rcg_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data;
          rcg_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (fst_r)
        F_IDLE: begin
          if (accept) begin
            col_r <= CW'(cn_x);
            row_r <= RW'(rn_x);
            fst_r <= F_READ;
          end
        end
        F_READ: begin
          ul_r   <= upper;
          left_r <= cur_r;
          fst_r  <= F_IDLE;
        end
        default: fst_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/rcg_back.sv =====
module rcg_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  output logic                              q_pop,
  input  logic [$clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH)
                + 4 * rcg_pkg::PIX_W + 3 - 1:0] q_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rcg_pkg::COORD_OUT_W-1:0]   out_row,
  output logic [rcg_pkg::COORD_OUT_W-1:0]   out_col,
  output rcg_pkg::pix_t                     out_value,
  output logic                              out_is_copy,
  output logic                              out_last_of_run
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SQ_W = rcg_pkg::SQ_W;
  localparam logic [SQ_W-1:0] SQ_TOP = SQ_W'(1) << (SQ_W - 1);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SQRT = 2'd1;
  localparam logic [1:0] B_EMIT = 2'd2;

  rcg_pkg::rcg_flags_t qf, pm_r, pm_left;
  logic [RW-1:0]       qr, br_r, o_row;
  logic [CW-1:0]       qc, bc_r, o_col;
  rcg_pkg::pix_t       qcur, qup, qul, qleft, cur_b_r, up_b_r, mag_r, o_val;
  logic                o_copy;
  logic signed [8:0]   d1, d2;
  logic signed [17:0]  sq1, sq2;
  logic [SQ_W-1:0]     s, rem_r, res_r, bit_r, trial, rem_nxt, res_nxt;
  logic [1:0]          bst_r;
  logic                out_valid_r, ld, emit;
  logic [rcg_pkg::COORD_OUT_W-1:0] out_row_r, out_col_r;
  rcg_pkg::pix_t       out_value_r;
  logic                out_is_copy_r, out_last_r;

  assign {qf, qr, qc, qcur, qup, qul, qleft} = q_data;

  always_comb begin
    d1  = $signed({1'b0, qul}) - $signed({1'b0, qcur});
    d2  = $signed({1'b0, qleft}) - $signed({1'b0, qup});
    sq1 = d1 * d1;
    sq2 = d2 * d2;
    s   = SQ_W'(sq1) + SQ_W'(sq2);
  end

  always_comb begin
    trial = res_r + bit_r;
    if (rem_r >= trial) begin
      rem_nxt = rem_r - trial;
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      rem_nxt = rem_r;
      res_nxt = res_r >> 1;
    end
  end

  always_comb begin
    pm_left = pm_r;
    if (pm_r.grad) begin
      o_row        = br_r - RW'(1);
      o_col        = bc_r - CW'(1);
      o_val        = mag_r;
      o_copy       = 1'b0;
      pm_left.grad = 1'b0;
    end else if (pm_r.copy_up) begin
      o_row           = br_r - RW'(1);
      o_col           = bc_r;
      o_val           = up_b_r;
      o_copy          = 1'b1;
      pm_left.copy_up = 1'b0;
    end else begin
      o_row             = br_r;
      o_col             = bc_r;
      o_val             = cur_b_r;
      o_copy            = 1'b1;
      pm_left.copy_self = 1'b0;
    end
  end

  assign q_pop = (bst_r == B_IDLE) && !q_empty;
  assign ld    = !out_valid_r || out_ready;
  assign emit  = (bst_r == B_EMIT) && ld;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      br_r    <= qr;
      bc_r    <= qc;
      cur_b_r <= qcur;
      up_b_r  <= qup;
      rem_r   <= s;
      res_r   <= '0;
      bit_r   <= SQ_TOP;
    end else if (bst_r == B_SQRT) begin
      rem_r <= rem_nxt;
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
      if (bit_r == SQ_W'(1)) begin
        mag_r <= (res_nxt > SQ_W'(255)) ? 8'hFF : res_nxt[7:0];
      end
    end
    if (emit) begin
      out_row_r     <= rcg_pkg::COORD_OUT_W'(o_row);
      out_col_r     <= rcg_pkg::COORD_OUT_W'(o_col);
      out_value_r   <= o_val;
      out_is_copy_r <= o_copy;
      out_last_r    <= (pm_left == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r       <= B_IDLE;
      pm_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (bst_r)
        B_IDLE: begin
          if (q_pop && (qf != '0)) begin
            pm_r  <= qf;
            bst_r <= qf.grad ? B_SQRT : B_EMIT;
          end
        end
        B_SQRT: begin
          if (bit_r == SQ_W'(1)) begin
            bst_r <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (emit) begin
            pm_r <= pm_left;
            if (pm_left == '0) begin
              bst_r <= B_IDLE;
            end
          end
        end
        default: bst_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_value       = out_value_r;
  assign out_is_copy     = out_is_copy_r;
  assign out_last_of_run = out_last_r;

endmodule

// ===== sv/roberts_cross_gradient_top.sv =====
// Roberts cross edge filter for a stream of 8-bit gray pixels in raster order.
// Pixels enter on the in_ channel; each request may cause up to three results on
// the out_ channel: the gradient of the window it completes, the copy of the
// last pixel of the row above and the copy of itself in the last row. The final
// result of a pixel is marked by out_last_of_run. The cfg_ channel sets the image
// width and height and is always ready; write it only while the block is idle.
// The front takes no new pixel while it waits for the registered read of the
// line store. The back fetches a job, works out the square root when a gradient
// is due and then gives one result per cycle while the receiver keeps up; it
// fetches no new job until it has issued the last result of the current one. A
// two-entry queue separates the two halves. Reset restores a 640 by 480 frame
// and restarts counting at row 0, column 0; the line store is not cleared. When
// the receiver stalls, the result holds in the output register, the back waits
// and the queue fills, after which in_ready falls until space returns.
module roberts_cross_gradient_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rcg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcg_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rcg_pkg::pix_t                    in_gray_pixel,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rcg_pkg::COORD_OUT_W-1:0]  out_row,
  output logic [rcg_pkg::COORD_OUT_W-1:0]  out_col,
  output rcg_pkg::pix_t                    out_value,
  output logic                             out_is_copy,
  output logic                             out_last_of_run
);

  localparam int JOB_W = $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH)
                         + 4 * rcg_pkg::PIX_W + 3;
  localparam int Q_DEPTH = 2;

  logic             q_push, q_pop, q_full, q_empty;
  logic [JOB_W-1:0] q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  rcg_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_gray_pixel (in_gray_pixel),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  rcg_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  rcg_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .q_data          (q_rdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_value       (out_value),
    .out_is_copy     (out_is_copy),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== sv/rcg_checker.sv =====
module rcg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [rcg_pkg::COORD_OUT_W-1:0] out_row,
  input logic [rcg_pkg::COORD_OUT_W-1:0] out_col,
  input rcg_pkg::pix_t                   out_value,
  input logic                            out_is_copy,
  input logic                            out_last_of_run
);

  // A stalled result must hold still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(out_value) && $stable(out_is_copy) && $stable(out_last_of_run))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // The front takes no request in the cycle after it accepts one, while it reads the line store.
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken during a line store read");

  // The results of one pixel leave without gaps while the receiver keeps up.
  a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid)
    else $error("gap inside a run of results");

endmodule

bind roberts_cross_gradient_top rcg_checker u_rcg_checker (.*);
